// ===== rtl/clw_pkg.sv =====
// clw_pkg: shared types and constants for the lease watchdog.
// Request/response structs, request and status codes, period limits.
// No dependencies.
package clw_pkg;

    typedef enum logic [2:0] {
        REQ_CONFIGURE = 3'd0,
        REQ_HEARTBEAT = 3'd1,
        REQ_STOP      = 3'd2,
        REQ_CLEANUP   = 3'd3,
        REQ_HEALTH    = 3'd4,
        REQ_REDIRECT  = 3'd5
    } req_type_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_DENIED     = 3'd2,
        ST_BAD_HANDLE = 3'd3,
        ST_BUSY       = 3'd4
    } status_t;

    localparam int LIMIT_W = 30;    // 16-bit period times 10000 fits in 30 bits

    localparam logic [13:0]        TICKS_PER_MS = 14'd10000;
    localparam logic [15:0]        PERIOD_MIN   = 16'd2000;
    localparam logic [15:0]        PERIOD_MAX   = 16'd60000;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN    = LIMIT_W'(2000 * 10000);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX    = LIMIT_W'(60000 * 10000);
    localparam logic [7:0]         FAMILY_V4    = 8'd4;
    localparam logic [7:0]         FAMILY_V6    = 8'd6;

    typedef struct packed {
        req_type_t   req_type;
        logic [31:0] requestor_pid;
        logic [31:0] handle_id;
        logic [31:0] new_owner_pid;
        logic [15:0] new_port_v4;
        logic [15:0] new_port_v6;
        logic [15:0] new_period_ms;
        logic [63:0] now_ticks;
        logic [7:0]  addr_family;
        logic [63:0] flow_generation;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic        healthy;
        logic        failed_open;
        logic        redirect_ok;
        logic [31:0] redirect_pid;
        logic [15:0] redirect_port;
        logic [63:0] current_generation;
    } rsp_t;

endpackage

// ===== rtl/clw_in_stage.sv =====
// clw_in_stage: input register for one request.
// Depends on clw_pkg (req_t).
module clw_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  clw_pkg::req_t req_in,
    input  logic          advance,
    output logic          req_vld,
    output clw_pkg::req_t req_out
);
    import clw_pkg::*;

    logic vld_reg;
    logic vld_next;
    req_t req_reg;

    assign s_ready = !vld_reg || advance;

    always_comb begin
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (advance) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= req_in;
        end
    end

    assign req_vld = vld_reg;
    assign req_out = req_reg;

endmodule

// ===== rtl/clw_core.sv =====
// clw_core: lease state registers and the combinational request evaluation.
// Depends on clw_pkg (req_t, rsp_t, codes, limits).
module clw_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  clw_pkg::req_t req,
    output clw_pkg::rsp_t rsp
);
    import clw_pkg::*;

    logic               lease_active_reg,    lease_active_next;
    logic [63:0]        lease_generation_reg, lease_generation_next;
    logic [31:0]        owner_pid_reg,       owner_pid_next;
    logic [31:0]        owner_handle_reg,    owner_handle_next;
    logic [15:0]        port_v4_reg,         port_v4_next;
    logic [15:0]        port_v6_reg,         port_v6_next;
    logic [LIMIT_W-1:0] limit_reg,           limit_next;   // period_ms * 10000
    logic [63:0]        last_beat_reg,       last_beat_next;

    logic               cfg_bad;
    logic               owns;
    logic [LIMIT_W-1:0] limit_new;
    logic [63:0]        age;
    logic               fresh;
    logic [63:0]        gen_inc;
    logic [63:0]        gen_bump;
    logic               fam_ok;
    logic               gen_match;
    logic [15:0]        fam_port;
    logic               tear;

    assign cfg_bad = (req.new_owner_pid == '0) || (req.new_port_v4 == '0) ||
                     (req.new_port_v6 == '0) || (req.new_period_ms < PERIOD_MIN) ||
                     (req.new_period_ms > PERIOD_MAX);
    assign owns = lease_active_reg && (req.handle_id != '0) &&
                  (req.handle_id == owner_handle_reg) &&
                  (req.requestor_pid != '0) && (req.requestor_pid == owner_pid_reg);
    assign limit_new = LIMIT_W'(LIMIT_W'(req.new_period_ms) * LIMIT_W'(TICKS_PER_MS));
    assign age   = req.now_ticks - last_beat_reg;
    // clock behind the last beat counts as stale
    assign fresh = (owner_pid_reg != '0) && (limit_reg != '0) &&
                   (req.now_ticks >= last_beat_reg) &&
                   (age <= {{(64-LIMIT_W){1'b0}}, limit_reg});
    assign gen_inc   = lease_generation_reg + 64'd1;
    assign gen_bump  = (gen_inc == '0) ? 64'd1 : gen_inc;
    assign fam_ok    = (req.addr_family == FAMILY_V4) || (req.addr_family == FAMILY_V6);
    assign gen_match = (req.flow_generation != '0) &&
                       (req.flow_generation == lease_generation_reg);
    assign fam_port  = (req.addr_family == FAMILY_V4) ? port_v4_reg : port_v6_reg;

    always_comb begin
        lease_active_next     = lease_active_reg;
        lease_generation_next = lease_generation_reg;
        owner_pid_next        = owner_pid_reg;
        owner_handle_next     = owner_handle_reg;
        port_v4_next          = port_v4_reg;
        port_v6_next          = port_v6_reg;
        limit_next            = limit_reg;
        last_beat_next        = last_beat_reg;
        tear                  = 1'b0;
        rsp                   = '0;
        rsp.status            = ST_OK;

        case (req.req_type)
            REQ_CONFIGURE: begin
                if (cfg_bad) begin
                    rsp.status = ST_INVALID;
                end else if ((req.requestor_pid == '0) ||
                             (req.requestor_pid != req.new_owner_pid)) begin
                    rsp.status = ST_DENIED;
                end else if (req.handle_id == '0) begin
                    rsp.status = ST_BAD_HANDLE;
                end else if (lease_active_reg && (owner_handle_reg != req.handle_id)) begin
                    rsp.status = ST_BUSY;
                end else begin
                    if (!lease_active_reg) begin
                        lease_generation_next = gen_bump;
                    end
                    owner_pid_next    = req.new_owner_pid;
                    owner_handle_next = req.handle_id;
                    port_v4_next      = req.new_port_v4;
                    port_v6_next      = req.new_port_v6;
                    limit_next        = limit_new;
                    last_beat_next    = req.now_ticks;
                    lease_active_next = 1'b1;
                end
            end
            REQ_HEARTBEAT: begin
                if (owns) begin
                    last_beat_next = req.now_ticks;
                end else begin
                    rsp.status = ST_DENIED;
                end
            end
            REQ_STOP: begin
                if (lease_active_reg) begin
                    if (owns) begin
                        tear = 1'b1;
                    end else begin
                        rsp.status = ST_DENIED;
                    end
                end
            end
            REQ_CLEANUP: begin
                tear = (req.handle_id != '0) && lease_active_reg &&
                       (owner_handle_reg == req.handle_id);
            end
            REQ_HEALTH: begin
                if (lease_active_reg) begin
                    rsp.healthy = fresh;
                    tear        = !fresh;
                end
            end
            REQ_REDIRECT: begin
                if (fam_ok && lease_active_reg && gen_match) begin
                    rsp.redirect_pid  = owner_pid_reg;
                    rsp.redirect_port = fam_port;
                    rsp.redirect_ok   = (owner_pid_reg != '0) && (fam_port != '0);
                end
            end
            default: begin
                rsp.status = ST_INVALID;
            end
        endcase

        // fail-open: drop owner fields, keep generation
        if (tear) begin
            lease_active_next = 1'b0;
            owner_pid_next    = '0;
            owner_handle_next = '0;
            port_v4_next      = '0;
            port_v6_next      = '0;
            limit_next        = '0;
            last_beat_next    = '0;
        end

        rsp.failed_open        = tear;
        rsp.current_generation = lease_active_next ? lease_generation_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lease_active_reg     <= 1'b0;
            lease_generation_reg <= '0;
            owner_pid_reg        <= '0;
            owner_handle_reg     <= '0;
            port_v4_reg          <= '0;
            port_v6_reg          <= '0;
            limit_reg            <= '0;
            last_beat_reg        <= '0;
        end else if (fire) begin
            lease_active_reg     <= lease_active_next;
            lease_generation_reg <= lease_generation_next;
            owner_pid_reg        <= owner_pid_next;
            owner_handle_reg     <= owner_handle_next;
            port_v4_reg          <= port_v4_next;
            port_v6_reg          <= port_v6_next;
            limit_reg            <= limit_next;
            last_beat_reg        <= last_beat_next;
        end
    end

    a_idle_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        !lease_active_reg |-> (owner_handle_reg == '0 && owner_pid_reg == '0))
        else $error("idle lease holds owner fields");

    a_gen_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lease_active_reg |-> (lease_generation_reg != '0))
        else $error("active lease with zero generation");

    a_limit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lease_active_reg |-> (limit_reg >= LIMIT_MIN && limit_reg <= LIMIT_MAX))
        else $error("active lease with out-of-range period");

    a_tear_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && tear) |=> !lease_active_reg)
        else $error("lease still active after fail-open");

endmodule

// ===== rtl/clw_out_stage.sv =====
// clw_out_stage: result register toward the m_ side.
// Depends on clw_pkg (rsp_t).
module clw_out_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_vld,
    input  clw_pkg::rsp_t rsp_in,
    output logic          advance,
    output logic          fire,
    output logic          m_valid,
    input  logic          m_ready,
    output clw_pkg::rsp_t rsp_out
);
    import clw_pkg::*;

    logic vld_reg;
    logic vld_next;
    rsp_t rsp_reg;

    assign advance = !vld_reg || m_ready;
    assign fire    = req_vld && advance;

    always_comb begin
        vld_next = vld_reg;
        if (fire) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            rsp_reg <= rsp_in;
        end
    end

    assign m_valid = vld_reg;
    assign rsp_out = rsp_reg;

endmodule

// ===== rtl/controller_lease_watchdog.sv =====
// controller_lease_watchdog: owner lease with heartbeat watchdog.
// A request waits in the input register and its result in the result register.
// Throughput: one request per cycle while m_ready is high. The lease state
// updates as a request leaves the input register, so the next one sees it.
// Reset (aresetn low, synchronous): lease idle, generation 0, owner cleared,
// both pipeline registers empty.
module controller_lease_watchdog (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_requestor_pid,
    input  logic [31:0] s_handle_id,
    input  logic [31:0] s_new_owner_pid,
    input  logic [15:0] s_new_port_v4,
    input  logic [15:0] s_new_port_v6,
    input  logic [15:0] s_new_period_ms,
    input  logic [63:0] s_now_ticks,
    input  logic [7:0]  s_addr_family,
    input  logic [63:0] s_flow_generation,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_healthy,
    output logic        m_failed_open,
    output logic        m_redirect_ok,
    output logic [31:0] m_redirect_pid,
    output logic [15:0] m_redirect_port,
    output logic [63:0] m_current_generation
);
    import clw_pkg::*;

    req_t req_in;
    req_t req_q;
    logic req_vld;
    rsp_t rsp_d;
    rsp_t rsp_q;
    logic advance;   // result register can take a new result this cycle
    logic fire;      // request in the input register is evaluated and retired

    // pack the request ports; codes 6 and 7 pass through and get status invalid
    assign req_in.req_type        = req_type_t'(s_req_type);
    assign req_in.requestor_pid   = s_requestor_pid;
    assign req_in.handle_id       = s_handle_id;
    assign req_in.new_owner_pid   = s_new_owner_pid;
    assign req_in.new_port_v4     = s_new_port_v4;
    assign req_in.new_port_v6     = s_new_port_v6;
    assign req_in.new_period_ms   = s_new_period_ms;
    assign req_in.now_ticks       = s_now_ticks;
    assign req_in.addr_family     = s_addr_family;
    assign req_in.flow_generation = s_flow_generation;

    // stage 1: input register, refilled whenever its content moves on
    clw_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .req_in  (req_in),
        .advance (advance),
        .req_vld (req_vld),
        .req_out (req_q)
    );

    // lease state plus the compare/update logic for one request
    clw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (req_q),
        .rsp     (rsp_d)
    );

    // stage 2: result register; a held result stalls only the input stage
    clw_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_vld (req_vld),
        .rsp_in  (rsp_d),
        .advance (advance),
        .fire    (fire),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .rsp_out (rsp_q)
    );

    assign m_status             = rsp_q.status;
    assign m_healthy            = rsp_q.healthy;
    assign m_failed_open        = rsp_q.failed_open;
    assign m_redirect_ok        = rsp_q.redirect_ok;
    assign m_redirect_pid       = rsp_q.redirect_pid;
    assign m_redirect_port      = rsp_q.redirect_port;
    assign m_current_generation = rsp_q.current_generation;

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for controller_lease_watchdog.
// Predicts every response from its own lease model and compares it field by field.
// Depends on clw_pkg (codes, limits, response struct) and the RTL top level.
`timescale 1ns / 1ps

module testbench;
    import clw_pkg::*;

    // Request codes the block has no meaning for; both must answer invalid.
    localparam logic [2:0] REQ_RSVD_A = 3'd6;
    localparam logic [2:0] REQ_RSVD_B = 3'd7;

    // Run limit, far above what the slowest legal run needs (~1550 requests
    // with long gaps and long result stalls).
    localparam int CYCLE_LIMIT = 1000000;

    // One request as the bench builds it. req_type is a plain 3-bit field so
    // the unused codes can be sent as well.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] requestor_pid;
        logic [31:0] handle_id;
        logic [31:0] new_owner_pid;
        logic [15:0] new_port_v4;
        logic [15:0] new_port_v6;
        logic [15:0] new_period_ms;
        logic [63:0] now_ticks;
        logic [7:0]  addr_family;
        logic [63:0] flow_generation;
    } lease_req_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type        = '0;
    logic [31:0] s_requestor_pid   = '0;
    logic [31:0] s_handle_id       = '0;
    logic [31:0] s_new_owner_pid   = '0;
    logic [15:0] s_new_port_v4     = '0;
    logic [15:0] s_new_port_v6     = '0;
    logic [15:0] s_new_period_ms   = '0;
    logic [63:0] s_now_ticks       = '0;
    logic [7:0]  s_addr_family     = '0;
    logic [63:0] s_flow_generation = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_healthy;
    logic        m_failed_open;
    logic        m_redirect_ok;
    logic [31:0] m_redirect_pid;
    logic [15:0] m_redirect_port;
    logic [63:0] m_current_generation;

    initial forever #5 aclk = ~aclk;

    controller_lease_watchdog DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_req_type           (s_req_type),
        .s_requestor_pid      (s_requestor_pid),
        .s_handle_id          (s_handle_id),
        .s_new_owner_pid      (s_new_owner_pid),
        .s_new_port_v4        (s_new_port_v4),
        .s_new_port_v6        (s_new_port_v6),
        .s_new_period_ms      (s_new_period_ms),
        .s_now_ticks          (s_now_ticks),
        .s_addr_family        (s_addr_family),
        .s_flow_generation    (s_flow_generation),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_healthy            (m_healthy),
        .m_failed_open        (m_failed_open),
        .m_redirect_ok        (m_redirect_ok),
        .m_redirect_pid       (m_redirect_pid),
        .m_redirect_port      (m_redirect_port),
        .m_current_generation (m_current_generation)
    );

    // ------------------------------------------------------------------
    // Bench-side copy of the lease. Updated in acceptance order, so it
    // always reflects every request the block has taken so far.
    // ------------------------------------------------------------------
    logic        lease_live;
    logic [63:0] lease_gen;
    logic [31:0] own_pid;
    logic [31:0] own_handle;
    logic [15:0] own_v4;
    logic [15:0] own_v6;
    logic [15:0] own_period;
    logic [63:0] beat_ticks;

    rsp_t        pending_replies[$];   // responses owed by the block, oldest first
    int          error_count = 0;
    int          cycle_count = 0;
    bit          no_gaps     = 1'b0;   // set for back-to-back stretches

    // Session stimulus: a small cast of callers so ids collide often.
    logic [31:0] caller_pids[3];
    logic [31:0] caller_handles[3];
    logic [63:0] wall_ticks;

    // Teardown: owner fields cleared in one go, generation kept.
    function automatic void drop_lease();
        lease_live = 1'b0;
        own_pid    = '0;
        own_handle = '0;
        own_v4     = '0;
        own_v6     = '0;
        own_period = '0;
        beat_ticks = '0;
    endfunction

    function automatic logic is_owner(logic [31:0] handle, logic [31:0] pid);
        return lease_live && handle != 0 && handle == own_handle &&
               pid != 0 && pid == own_pid;
    endfunction

    // Applies one request to the lease copy and returns the response it owes.
    function automatic rsp_t predict_lease_reply(lease_req_t rq);
        rsp_t        rs;
        logic [63:0] limit;
        rs        = '0;
        rs.status = ST_OK;
        case (rq.req_type)
            REQ_CONFIGURE: begin
                // Check order matters: params, then caller, then handle, then busy.
                if (rq.new_owner_pid == 0 || rq.new_port_v4 == 0 || rq.new_port_v6 == 0 ||
                    rq.new_period_ms < PERIOD_MIN || rq.new_period_ms > PERIOD_MAX) begin
                    rs.status = ST_INVALID;
                end else if (rq.requestor_pid == 0 ||
                             rq.requestor_pid != rq.new_owner_pid) begin
                    rs.status = ST_DENIED;
                end else if (rq.handle_id == 0) begin
                    rs.status = ST_BAD_HANDLE;
                end else if (lease_live && own_handle != rq.handle_id) begin
                    rs.status = ST_BUSY;
                end else begin
                    // New lease bumps the generation, never landing on zero;
                    // a refresh by the owner keeps it.
                    if (!lease_live) begin
                        lease_gen = lease_gen + 64'd1;
                        if (lease_gen == 0)
                            lease_gen = 64'd1;
                    end
                    own_pid    = rq.new_owner_pid;
                    own_handle = rq.handle_id;
                    own_v4     = rq.new_port_v4;
                    own_v6     = rq.new_port_v6;
                    own_period = rq.new_period_ms;
                    beat_ticks = rq.now_ticks;
                    lease_live = 1'b1;
                end
            end
            REQ_HEARTBEAT: begin
                if (is_owner(rq.handle_id, rq.requestor_pid))
                    beat_ticks = rq.now_ticks;
                else
                    rs.status = ST_DENIED;
            end
            REQ_STOP: begin
                // Idle lease: quietly ok.
                if (lease_live) begin
                    if (is_owner(rq.handle_id, rq.requestor_pid)) begin
                        drop_lease();
                        rs.failed_open = 1'b1;
                    end else begin
                        rs.status = ST_DENIED;
                    end
                end
            end
            REQ_CLEANUP: begin
                // Matches on handle only; always ok.
                if (rq.handle_id != 0 && lease_live && own_handle == rq.handle_id) begin
                    drop_lease();
                    rs.failed_open = 1'b1;
                end
            end
            REQ_HEALTH: begin
                if (lease_live) begin
                    limit = 64'(own_period) * 64'(TICKS_PER_MS);
                    // A clock that runs behind the last beat counts as stale.
                    rs.healthy = own_pid != 0 && own_period != 0 &&
                                 rq.now_ticks >= beat_ticks &&
                                 (rq.now_ticks - beat_ticks) <= limit;
                    if (!rs.healthy) begin
                        drop_lease();
                        rs.failed_open = 1'b1;
                    end
                end
            end
            REQ_REDIRECT: begin
                if ((rq.addr_family == FAMILY_V4 || rq.addr_family == FAMILY_V6) &&
                    lease_live && rq.flow_generation != 0 &&
                    rq.flow_generation == lease_gen) begin
                    rs.redirect_pid  = own_pid;
                    rs.redirect_port = (rq.addr_family == FAMILY_V4) ? own_v4 : own_v6;
                    rs.redirect_ok   = rs.redirect_pid != 0 && rs.redirect_port != 0;
                end
            end
            default: rs.status = ST_INVALID;
        endcase
        rs.current_generation = lease_live ? lease_gen : 64'd0;
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Sends one request and books its expected response at acceptance.
    // Called at a rising edge; returns at the edge that took the request.
    task automatic push_request(lease_req_t rq);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_req_type        <= rq.req_type;
        s_requestor_pid   <= rq.requestor_pid;
        s_handle_id       <= rq.handle_id;
        s_new_owner_pid   <= rq.new_owner_pid;
        s_new_port_v4     <= rq.new_port_v4;
        s_new_port_v6     <= rq.new_port_v6;
        s_new_period_ms   <= rq.new_period_ms;
        s_now_ticks       <= rq.now_ticks;
        s_addr_family     <= rq.addr_family;
        s_flow_generation <= rq.flow_generation;
        s_valid           <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_replies.push_back(predict_lease_reply(rq));
    endtask

    task automatic send_configure(logic [31:0] caller, owner, handle,
                                  logic [15:0] v4, v6, period, logic [63:0] now);
        lease_req_t rq;
        rq               = '0;
        rq.req_type      = REQ_CONFIGURE;
        rq.requestor_pid = caller;
        rq.new_owner_pid = owner;
        rq.handle_id     = handle;
        rq.new_port_v4   = v4;
        rq.new_port_v6   = v6;
        rq.new_period_ms = period;
        rq.now_ticks     = now;
        push_request(rq);
    endtask

    // Heartbeat, stop, cleanup, health and the unused codes.
    task automatic send_call(logic [2:0] kind, logic [31:0] caller, handle,
                             logic [63:0] now);
        lease_req_t rq;
        rq               = '0;
        rq.req_type      = kind;
        rq.requestor_pid = caller;
        rq.handle_id     = handle;
        rq.now_ticks     = now;
        push_request(rq);
    endtask

    task automatic send_redirect(logic [7:0] family, logic [63:0] gen);
        lease_req_t rq;
        rq                 = '0;
        rq.req_type        = REQ_REDIRECT;
        rq.addr_family     = family;
        rq.flow_generation = gen;
        push_request(rq);
    endtask

    // Every field random, every code including the unused ones.
    function automatic lease_req_t random_req();
        lease_req_t rq;
        rq.req_type        = 3'($urandom_range(0, 7));
        rq.requestor_pid   = $urandom;
        rq.handle_id       = $urandom;
        rq.new_owner_pid   = $urandom;
        rq.new_port_v4     = 16'($urandom);
        rq.new_port_v6     = 16'($urandom);
        rq.new_period_ms   = 16'($urandom);
        rq.now_ticks       = {$urandom, $urandom};
        rq.addr_family     = 8'($urandom);
        rq.flow_generation = {$urandom, $urandom};
        return rq;
    endfunction

    // Fresh cast of callers; some share a pid or a handle so busy,
    // denied and handle-only cleanup all turn up.
    function automatic void pick_callers();
        for (int i = 0; i < 3; i++) begin
            caller_pids[i]    = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
            caller_handles[i] = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
        end
        if ($urandom_range(0, 1) == 0)
            caller_pids[2] = caller_pids[0];
        if ($urandom_range(0, 2) == 0)
            caller_handles[1] = caller_handles[0];
        wall_ticks = {$urandom, $urandom};
    endfunction

    // Well-formed session traffic with random content: the owner mostly
    // speaks for itself, time moves forward, health checks probe the edge
    // of the watchdog window.
    function automatic lease_req_t make_session_req();
        lease_req_t  rq;
        int          who;
        int          pick;
        int          r;
        logic [63:0] limit;
        rq                = random_req();
        who               = $urandom_range(0, 2);
        rq.requestor_pid  = caller_pids[who];
        rq.handle_id      = caller_handles[who];
        if (lease_live && $urandom_range(0, 9) < 6) begin
            rq.requestor_pid = own_pid;
            rq.handle_id     = own_handle;
        end
        wall_ticks   = wall_ticks + 64'($urandom_range(0, 2000000));
        rq.now_ticks = wall_ticks;
        pick         = $urandom_range(0, 99);
        if (pick < 20) begin
            rq.req_type = REQ_CONFIGURE;
            if ($urandom_range(0, 9) != 0)
                rq.new_owner_pid = rq.requestor_pid;
            if ($urandom_range(0, 19) != 0)
                rq.new_port_v4 = 16'($urandom_range(1, 65535));
            if ($urandom_range(0, 19) != 0)
                rq.new_port_v6 = 16'($urandom_range(1, 65535));
            if ($urandom_range(0, 9) != 0)
                rq.new_period_ms = 16'($urandom_range(PERIOD_MIN, PERIOD_MAX));
        end else if (pick < 42) begin
            rq.req_type = REQ_HEARTBEAT;
        end else if (pick < 60) begin
            rq.req_type = REQ_REDIRECT;
            r = $urandom_range(0, 9);
            if (r < 4)
                rq.addr_family = FAMILY_V4;
            else if (r < 8)
                rq.addr_family = FAMILY_V6;
            r = $urandom_range(0, 9);
            if (r < 7)
                rq.flow_generation = lease_gen;
            else if (r == 7)
                rq.flow_generation = lease_gen + 64'd1;
            else if (r == 8)
                rq.flow_generation = '0;
        end else if (pick < 78) begin
            rq.req_type = REQ_HEALTH;
            limit       = 64'(own_period) * 64'(TICKS_PER_MS);
            r           = $urandom_range(0, 9);
            if (r < 4)
                rq.now_ticks = beat_ticks + 64'($urandom_range(0, limit[31:0]));
            else if (r < 6)  // right at the window edge
                rq.now_ticks = beat_ticks + limit + 64'($urandom_range(0, 2)) - 64'd1;
            else if (r < 8)  // well past it
                rq.now_ticks = beat_ticks + limit + 64'($urandom_range(2, 400000000));
            else if (r == 8) // clock behind the last beat
                rq.now_ticks = beat_ticks - 64'($urandom_range(1, 1000));
        end else if (pick < 88) begin
            rq.req_type = REQ_STOP;
        end else if (pick < 96) begin
            rq.req_type = REQ_CLEANUP;
        end
        // The rest keeps its random code: noise, unused codes included.
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Edges of every field and the corner behaviors, one at a time.
    task automatic test_request_checks();
        // Idle lease: health, redirect and stop all answer ok with nothing done.
        send_call(REQ_HEALTH, 32'd5, 32'd5, 64'd0);
        send_redirect(FAMILY_V4, 64'd0);
        send_call(REQ_STOP, 32'd7, 32'd7, 64'd0);
        send_call(REQ_RSVD_A, 32'd7, 32'd7, 64'd0);
        send_call(REQ_RSVD_B, 32'd7, 32'd7, 64'd0);
        // Parameter checks win over caller and handle checks.
        send_configure(32'd0, 32'd0, 32'd0, 16'd1, 16'd1, PERIOD_MIN, 64'd0);
        send_configure(32'd9, 32'd9, 32'd1, 16'd0, 16'd1, PERIOD_MIN, 64'd0);
        send_configure(32'd9, 32'd9, 32'd1, 16'd1, 16'd0, PERIOD_MIN, 64'd0);
        send_configure(32'd9, 32'd9, 32'd1, 16'd1, 16'd1, PERIOD_MIN - 16'd1, 64'd0);
        send_configure(32'd9, 32'd9, 32'd1, 16'd1, 16'd1, PERIOD_MAX + 16'd1, 64'd0);
        send_configure(32'd8, 32'd9, 32'd1, 16'd1, 16'd1, PERIOD_MAX, 64'd0);
        send_configure(32'd9, 32'd9, 32'd0, 16'd1, 16'd1, PERIOD_MAX, 64'd0);
        // Take the lease with every id at its top value.
        send_configure('1, '1, '1, '1, '1, PERIOD_MAX, 64'd0);
        // Someone else's handle while held: busy.
        send_configure(32'd1, 32'd1, 32'd1, 16'd1, 16'd1, PERIOD_MAX, 64'd5);
        // Right handle, wrong pid: heartbeat refused; owner beat accepted.
        send_call(REQ_HEARTBEAT, 32'd1, '1, 64'd50);
        send_call(REQ_HEARTBEAT, '1, '1, 64'd100);
        // Owner refresh: new ports and shortest period, same generation.
        send_configure('1, '1, '1, 16'd1, 16'd2, PERIOD_MIN, 64'd100);
        send_redirect(FAMILY_V4, lease_gen);
        send_redirect(FAMILY_V6, lease_gen);
        send_redirect(8'd5, lease_gen);
        send_redirect(FAMILY_V6, lease_gen + 64'd1);
        // Exactly at the window edge is still fresh; one tick later fails open.
        send_call(REQ_HEALTH, 32'd0, 32'd0, 64'd100 + 64'd20000000);
        send_call(REQ_HEALTH, 32'd0, 32'd0, 64'd100 + 64'd20000001);
        // Top of the clock, then a clock running behind the last beat.
        send_configure(32'h55, 32'h55, 32'hAAAA_AAAA, 16'h8000, 16'h7FFF, PERIOD_MIN, '1);
        send_call(REQ_HEALTH, 32'd0, 32'd0, '1);
        send_call(REQ_HEALTH, 32'd0, 32'd0, 64'd0);
        // Stop by a stranger is denied; cleanup needs the owner's nonzero handle.
        send_configure(32'h55, 32'h55, 32'hAAAA_AAAA, 16'd80, 16'd443, 16'd5000, 64'd10);
        send_call(REQ_STOP, 32'h56, 32'hAAAA_AAAA, 64'd20);
        send_call(REQ_CLEANUP, 32'h55, 32'd0, 64'd20);
        send_call(REQ_CLEANUP, 32'd0, 32'hAAAA_AAAA, 64'd20);
    endtask

    // Long random sessions with idling on both channels.
    task automatic test_lease_sessions();
        pick_callers();
        repeat (500) push_request(make_session_req());
        pick_callers();
        repeat (500) push_request(make_session_req());
    endtask

    // Same traffic at full rate, so each request sees the state its
    // predecessor just left behind.
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        pick_callers();
        repeat (300) push_request(make_session_req());
        no_gaps = 1'b0;
    endtask

    // Unshaped requests: every bit of every field, every code.
    task automatic test_noise();
        repeat (220) push_request(random_req());
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, then in-order compare.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int burst;
        forever begin
            stall = no_gaps ? 0 : pick_gap();
            burst = $urandom_range(1, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat (burst) @(posedge aclk);
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("response with no request outstanding");
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("status", 64'(want.status), 64'(m_status));
                check_field("healthy", 64'(want.healthy), 64'(m_healthy));
                check_field("failed_open", 64'(want.failed_open), 64'(m_failed_open));
                check_field("redirect_ok", 64'(want.redirect_ok), 64'(m_redirect_ok));
                check_field("redirect_pid", 64'(want.redirect_pid), 64'(m_redirect_pid));
                check_field("redirect_port", 64'(want.redirect_port), 64'(m_redirect_port));
                check_field("current_generation", want.current_generation,
                            m_current_generation);
            end
        end
    end

    // Watchdog on the bench itself.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        lease_gen = '0;
        drop_lease();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_request_checks();
        test_lease_sessions();
        test_back_to_back();
        test_noise();

        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        // Two-stage pipe; the extra edges below catch any stray response.
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
